/* hw/rtl/ilt_pkg.sv */
// ----------------------------------------------------------------------------
// ilt_pkg: shared types and constants for the indexed list table
// Operation and status codes, controller states and the default store depth.
// ----------------------------------------------------------------------------
package ilt_pkg;

  // default number of word slots
  localparam int unsigned DepthDefault = 256;

  // fixed field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 9;

  // request operations
  typedef enum logic [OpW-1:0] {
    OpAppend = 3'd0,
    OpInsert = 3'd1,
    OpEdit   = 3'd2,
    OpDelete = 3'd3,
    OpGet    = 3'd4,
    OpSearch = 3'd5
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatOk     = 3'd0,
    StatRange  = 3'd1,
    StatEmpty  = 3'd2,
    StatFull   = 3'd3,
    StatMiss   = 3'd4
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StCheck,
    StWalk,
    StPlace
  } state_e;

endpackage

/* hw/rtl/indexed_list_table.sv */
// ----------------------------------------------------------------------------
// indexed_list_table: packed list of signed words with a used count
// Append, insert, edit, delete, get and search over a single-port-read,
// single-port-write synchronous word memory walked one slot per cycle.
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  request   | start in, busy out      | op_i, index_i, value_i
//  result    | valid_o strobe, 1 cycle | status_o, data_o, position_o,
//            |                         | used_count_o, is_full_o, is_empty_o
//
//  Append, edit, failed requests and unused codes finish in the check state;
//  get reads its one slot in the walk state. Insert moves the words at and
//  above the index up a slot, then writes the new word in the place state;
//  delete moves the words above the index down a slot; search visits the
//  slots up to the first match, or every used slot on a miss.
//  Rate is set by the memory read port, one slot read per cycle.
//  Reset clears the count and the controller; word memory is not cleared.
//  The receiver cannot stall; a new request is taken in the strobe cycle.
//
module indexed_list_table
  import ilt_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [OpW-1:0]            op_i,
  input  logic [IndexW-1:0]         index_i,
  input  logic signed [WordW-1:0]   value_i,
  output logic                      valid_o,
  output logic [StatusW-1:0]        status_o,
  output logic signed [WordW-1:0]   data_o,
  output logic [IndexW-1:0]         position_o,
  output logic [CountW-1:0]         used_count_o,
  output logic                      is_full_o,
  output logic                      is_empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // controller and request registers
  state_e             state_q, state_d;
  op_e                op_q;
  logic [IndexW-1:0]  idx_q;
  logic [WordW-1:0]   val_q;
  logic [CW-1:0]      fill_q, fill_d;

  // walker registers
  logic [AW-1:0]      rptr_q, rptr_d;
  logic [CW-1:0]      rem_q, rem_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_tag_q, rd_tag_d;

  // result registers
  logic               valid_q, valid_d;
  status_e            status_q, status_d;
  logic [WordW-1:0]   data_q, data_d;
  logic [IndexW-1:0]  pos_q, pos_d;

  // memory ports
  logic [WordW-1:0]   mem [DEPTH];
  logic [WordW-1:0]   rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [WordW-1:0]   mem_wdata;

  // request checks
  logic               range_bad, used_bad, ins_gap, full_now;
  status_e            chk_status;
  logic               hit, walk_done, issue, accept;

  assign accept = start && (state_q == StIdle);

  // index and count checks in a common wide width
  assign range_bad = 32'(idx_q) >= 32'(DEPTH);
  assign used_bad  = 32'(idx_q) >= 32'(fill_q);
  assign ins_gap   = 32'(idx_q) >  32'(fill_q);
  assign full_now  = 32'(fill_q) >= 32'(DEPTH);

  // status of a request before any walk
  always_comb begin
    case (op_q)
      OpAppend: chk_status = full_now ? StatFull : StatOk;
      OpInsert: begin
        if (range_bad)     chk_status = StatRange;
        else if (ins_gap)  chk_status = StatEmpty;
        else if (full_now) chk_status = StatFull;
        else               chk_status = StatOk;
      end
      OpEdit, OpDelete, OpGet: begin
        if (range_bad)     chk_status = StatRange;
        else if (used_bad) chk_status = StatEmpty;
        else               chk_status = StatOk;
      end
      default: chk_status = StatOk;
    endcase
  end

  // walk control
  assign hit       = rd_vld_q && (op_q == OpSearch) && (rdata_q == val_q);
  assign walk_done = (rem_q == '0) || hit;
  assign issue     = (state_q == StWalk) && (rem_q != '0) && !hit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start) state_d = StCheck;
      end
      StCheck: begin
        if (chk_status == StatOk && (op_q == OpInsert || op_q == OpDelete ||
                                     op_q == OpGet || op_q == OpSearch)) begin
          state_d = StWalk;
        end else begin
          state_d = StIdle;
        end
      end
      StWalk: begin
        if (walk_done) state_d = (op_q == OpInsert) ? StPlace : StIdle;
      end
      StPlace: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // datapath and result control
  always_comb begin
    fill_d    = fill_q;
    rptr_d    = rptr_q;
    rem_d     = rem_q;
    rd_vld_d  = 1'b0;
    rd_tag_d  = rd_tag_q;
    valid_d   = 1'b0;
    status_d  = status_q;
    data_d    = data_q;
    pos_d     = pos_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(idx_q);
    mem_raddr = rptr_q;
    mem_wdata = val_q;
    case (state_q)
      StCheck: begin
        status_d = chk_status;
        data_d   = '0;
        pos_d    = '0;
        rem_d    = '0;
        rptr_d   = '0;
        if (chk_status == StatOk) begin
          case (op_q)
            OpAppend: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(fill_q);
              fill_d    = fill_q + CW'(1);
              valid_d   = 1'b1;
            end
            OpEdit: begin
              mem_we  = 1'b1;
              valid_d = 1'b1;
            end
            OpInsert: begin
              rem_d  = fill_q - CW'(idx_q);
              rptr_d = AW'(fill_q - CW'(1));
            end
            OpDelete: begin
              rem_d  = fill_q - CW'(1) - CW'(idx_q);
              rptr_d = AW'(idx_q) + AW'(1);
            end
            OpGet: begin
              rem_d  = CW'(1);
              rptr_d = AW'(idx_q);
            end
            OpSearch: begin
              rem_d  = fill_q;
            end
            default: valid_d = 1'b1;
          endcase
        end else begin
          valid_d = 1'b1;
        end
      end
      StWalk: begin
        // read one slot ahead
        if (issue) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_tag_d = rptr_q;
          rem_d    = rem_q - CW'(1);
          rptr_d   = (op_q == OpInsert) ? rptr_q - AW'(1) : rptr_q + AW'(1);
        end
        // write back the word read in the previous cycle
        if (rd_vld_q && op_q == OpInsert) begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_q + AW'(1);
          mem_wdata = rdata_q;
        end else if (rd_vld_q && op_q == OpDelete) begin
          mem_we    = 1'b1;
          mem_waddr = rd_tag_q - AW'(1);
          mem_wdata = rdata_q;
        end
        if (walk_done && op_q != OpInsert) begin
          valid_d = 1'b1;
          case (op_q)
            OpDelete: fill_d = fill_q - CW'(1);
            OpGet:    data_d = rdata_q;
            OpSearch: begin
              status_d = hit ? StatOk : StatMiss;
              pos_d    = hit ? IndexW'(rd_tag_q) : '0;
            end
            default: ;
          endcase
        end
      end
      StPlace: begin
        mem_we  = 1'b1;
        fill_d  = fill_q + CW'(1);
        valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      rem_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rem_q    <= rem_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(op_i);
      idx_q <= index_i;
      val_q <= value_i;
    end
    rptr_q   <= rptr_d;
    rd_tag_q <= rd_tag_d;
    status_q <= status_d;
    data_q   <= data_d;
    pos_q    <= pos_d;
  end

  // word memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  // outputs
  assign busy         = (state_q != StIdle);
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign data_o       = data_q;
  assign position_o   = pos_q;
  assign used_count_o = CountW'(fill_q);
  assign is_full_o    = full_now;
  assign is_empty_o   = (fill_q == '0);

  // count never passes the store size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= 32'(DEPTH))
    else $error("fill level above depth");

  // a result only shows once the controller is free again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // a request transfer always starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request transfer not taken");

  // shifting never reads and writes the same slot at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write collide on one slot");

  // reads are only in flight during a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == StWalk))
    else $error("memory read outside walk");

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for indexed_list_table
// Drives list requests through the start/busy handshake and predicts every
// result with a behavioral copy of the list. Results are matched in order.
// The random part sweeps the fill level between empty and full.
// ----------------------------------------------------------------------------
module tb_top;
  import ilt_pkg::*;

  localparam int unsigned ListDepth   = DepthDefault;
  localparam int unsigned RandomItems = 1650;
  localparam int unsigned CycleLimit  = 2500000;
  localparam int unsigned DrainCycles = 300;
  localparam int unsigned ErrorShow   = 10;

  // op codes the block does not define
  localparam logic [OpW-1:0] SpareOpA = 3'd6;
  localparam logic [OpW-1:0] SpareOpB = 3'd7;

  // one result transfer
  typedef struct packed {
    status_e                 status;
    logic signed [WordW-1:0] data;
    logic [IndexW-1:0]       position;
    logic [CountW-1:0]       used;
    logic                    full;
    logic                    empty;
  } list_result_t;

  // list contents, expected results and run statistics
  class list_scoreboard;
    logic signed [WordW-1:0] words [ListDepth];
    int unsigned             fill;
    list_result_t            pending [$];
    int unsigned             errors;
    int unsigned             op_seen [8];
    int unsigned             status_seen [8];
    int unsigned             peak_fill;
    int unsigned             results_seen;

    function new();
      fill         = 0;
      errors       = 0;
      peak_fill    = 0;
      results_seen = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= ErrorShow) $display("ERROR: %s", msg);
    endfunction

    // edit, delete and get need an existing slot in use
    function status_e slot_status(logic [IndexW-1:0] idx);
      if (idx >= ListDepth) return StatRange;
      if (idx >= fill) return StatEmpty;
      return StatOk;
    endfunction

    // apply an accepted request and queue the result it must produce
    function void take_request(logic [OpW-1:0] op, logic [IndexW-1:0] idx,
                               logic signed [WordW-1:0] val);
      list_result_t res;
      int unsigned  i;
      res.status   = StatOk;
      res.data     = '0;
      res.position = '0;
      op_seen[op]++;
      case (op)
        OpAppend: begin
          if (fill >= ListDepth) begin
            res.status = StatFull;
          end else begin
            words[fill] = val;
            fill++;
          end
        end
        OpInsert: begin
          if (idx >= ListDepth) res.status = StatRange;
          else if (idx > fill) res.status = StatEmpty;
          else if (fill >= ListDepth) res.status = StatFull;
          else begin
            // shift from the top down to open the slot
            for (i = fill; i > idx; i--) words[i] = words[i-1];
            words[idx] = val;
            fill++;
          end
        end
        OpEdit: begin
          res.status = slot_status(idx);
          if (res.status == StatOk) words[idx] = val;
        end
        OpDelete: begin
          res.status = slot_status(idx);
          if (res.status == StatOk) begin
            // close up the gap
            for (i = idx; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end
        end
        OpGet: begin
          res.status = slot_status(idx);
          if (res.status == StatOk) res.data = words[idx];
        end
        OpSearch: begin
          res.status = StatMiss;
          for (i = 0; i < fill; i++) begin
            if (words[i] == val) begin
              res.status   = StatOk;
              res.position = IndexW'(i);
              break;
            end
          end
        end
        default: ;
      endcase
      res.used  = CountW'(fill);
      res.full  = (fill >= ListDepth);
      res.empty = (fill == 0);
      if (fill > peak_fill) peak_fill = fill;
      status_seen[res.status]++;
      pending.push_back(res);
    endfunction

    // compare one result transfer against the oldest expectation
    function void match_result(list_result_t got);
      list_result_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: status %0d used %0d",
                         got.status, got.used));
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.data !== exp.data ||
          got.position !== exp.position || got.used !== exp.used ||
          got.full !== exp.full || got.empty !== exp.empty) begin
        report($sformatf({"result %0d exp/act: status %0d/%0d data %0d/%0d ",
                          "position %0d/%0d used %0d/%0d full %0b/%0b empty %0b/%0b"},
                         results_seen, exp.status, got.status, exp.data, got.data,
                         exp.position, got.position, exp.used, got.used,
                         exp.full, got.full, exp.empty, got.empty));
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic [OpW-1:0]          op_i;
  logic [IndexW-1:0]       index_i;
  logic signed [WordW-1:0] value_i;
  logic                    valid_o;
  logic [StatusW-1:0]      status_o;
  logic signed [WordW-1:0] data_o;
  logic [IndexW-1:0]       position_o;
  logic [CountW-1:0]       used_count_o;
  logic                    is_full_o;
  logic                    is_empty_o;

  list_scoreboard          list_sb;
  list_result_t            seen_result;
  int unsigned             cycles;
  bit                      growing;
  int unsigned             hold_at_end;
  bit                      bursty;

  // words that recur often so that searches hit duplicates
  logic signed [WordW-1:0] word_pool [8] = '{
    32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
    32'sh0000_0001, 32'sh0000_0007, 32'sh5555_5555, 32'shAAAA_AAAA
  };

  indexed_list_table #(
    .DEPTH(ListDepth)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .valid_o     (valid_o),
    .status_o    (status_o),
    .data_o      (data_o),
    .position_o  (position_o),
    .used_count_o(used_count_o),
    .is_full_o   (is_full_o),
    .is_empty_o  (is_empty_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               list_sb.pending.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      seen_result.status   = status_e'(status_o);
      seen_result.data     = data_o;
      seen_result.position = position_o;
      seen_result.used     = used_count_o;
      seen_result.full     = is_full_o;
      seen_result.empty    = is_empty_o;
      list_sb.match_result(seen_result);
    end
  end

  // one request transfer; start stays high afterwards for back-to-back items
  task automatic send_request(input logic [OpW-1:0] op, input logic [IndexW-1:0] idx,
                              input logic signed [WordW-1:0] val,
                              input int unsigned gap);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start   = 1'b1;
    op_i    = op;
    index_i = idx;
    value_i = val;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    list_sb.take_request(op, idx, val);
    @(negedge clk_i);
  endtask

  // mostly short gaps, a few long ones, none while bursting
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (bursty) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic signed [WordW-1:0] pick_word();
    if ($urandom_range(9) < 3) return word_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // index of a slot in use (any index on an empty list), leaning toward both ends of the list
  function automatic logic [IndexW-1:0] pick_used_index(int unsigned fill);
    if (fill == 0) return IndexW'($urandom_range(255));
    case ($urandom_range(7))
      0:       return '0;
      1:       return IndexW'(fill - 1);
      default: return IndexW'($urandom_range(fill - 1));
    endcase
  endfunction

  // next random request, steered to fill the list up and drain it again
  task automatic pick_request(output logic [OpW-1:0] op, output logic [IndexW-1:0] idx,
                              output logic signed [WordW-1:0] val);
    int unsigned fill;
    int unsigned r;
    int unsigned lim [6];
    op_e         noisy_ops [4];
    noisy_ops = '{OpInsert, OpEdit, OpDelete, OpGet};
    fill = list_sb.fill;
    // turn around after a few requests at either end
    if ((growing && fill == ListDepth) || (!growing && fill == 0)) begin
      hold_at_end++;
      if (hold_at_end > 5) begin
        growing     = !growing;
        hold_at_end = 0;
      end
    end else if ($urandom_range(249) == 0) begin
      growing = !growing;
    end
    if (growing) lim = '{40, 65, 72, 80, 88, 96};
    else         lim = '{10, 15, 60, 68, 78, 94};
    r   = $urandom_range(99);
    val = pick_word();
    idx = pick_used_index(fill);
    if (r < lim[0]) begin
      op = OpAppend;
    end else if (r < lim[1]) begin
      op  = OpInsert;
      idx = (fill >= ListDepth) ? IndexW'($urandom_range(255))
                                : IndexW'($urandom_range(fill));
    end else if (r < lim[2]) begin
      op = OpDelete;
    end else if (r < lim[3]) begin
      op = OpEdit;
    end else if (r < lim[4]) begin
      op = OpGet;
    end else if (r < lim[5]) begin
      op = OpSearch;
      if (fill > 0 && $urandom_range(2) != 0) val = list_sb.words[$urandom_range(fill - 1)];
    end else begin
      // noise: spare codes and indexes anywhere in range
      case ($urandom_range(3))
        0:       op = SpareOpA;
        1:       op = SpareOpB;
        default: op = noisy_ops[$urandom_range(3)];
      endcase
      idx = IndexW'($urandom_range(255));
    end
  endtask

  // directed requests: empty list, word extremes, duplicates, both list ends
  task automatic run_directed();
    send_request(OpGet,    8'd0,   32'sd0,         0);
    send_request(OpDelete, 8'd0,   32'sd0,         1);
    send_request(OpEdit,   8'd255, 32'sh7FFF_FFFF, 0);
    send_request(OpSearch, 8'd0,   32'sd0,         0);
    send_request(OpInsert, 8'd1,   32'sd5,         0);
    send_request(OpInsert, 8'd0,   32'sh8000_0000, 2);
    send_request(OpAppend, 8'd255, 32'sh7FFF_FFFF, 0);
    send_request(OpAppend, 8'd0,   -32'sd1,        0);
    send_request(OpAppend, 8'd0,   32'sd0,         0);
    send_request(OpInsert, 8'd4,   32'sd1,         0);
    send_request(OpInsert, 8'd2,   -32'sd1,        0);
    send_request(OpSearch, 8'd0,   -32'sd1,        0);
    send_request(OpSearch, 8'd0,   32'sd12345,     3);
    send_request(OpEdit,   8'd0,   32'sh5555_5555, 0);
    send_request(OpGet,    8'd0,   32'sd0,         0);
    send_request(OpGet,    8'd5,   32'sd0,         0);
    send_request(OpGet,    8'd6,   32'sd0,         0);
    send_request(OpDelete, 8'd0,   32'sd0,         0);
    send_request(OpDelete, 8'd4,   32'sd0,         0);
    send_request(SpareOpA, 8'd255, 32'shAAAA_AAAA, 0);
    send_request(SpareOpB, 8'd128, 32'sh8000_0000, 0);
    send_request(OpGet,    8'd255, 32'sd0,         0);
    send_request(OpSearch, 8'd0,   32'sh7FFF_FFFF, 0);
    send_request(OpSearch, 8'd0,   32'sh8000_0000, 0);
  endtask

  task automatic run_random();
    logic [OpW-1:0]          op;
    logic [IndexW-1:0]       idx;
    logic signed [WordW-1:0] val;
    growing     = 1'b1;
    hold_at_end = 0;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      // alternate gappy stretches with back-to-back bursts
      if (n % 64 == 0) bursty = ($urandom_range(3) == 0);
      pick_request(op, idx, val);
      send_request(op, idx, val, pick_gap());
    end
  endtask

  // stimulus and end of run
  initial begin
    cycles  = 0;
    bursty  = 1'b0;
    rst_ni  = 1'b0;
    start   = 1'b0;
    op_i    = OpAppend;
    index_i = '0;
    value_i = '0;
    list_sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    start = 1'b0;
    while (list_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d requests: append %0d insert %0d edit %0d delete %0d get %0d",
             list_sb.results_seen, list_sb.op_seen[OpAppend], list_sb.op_seen[OpInsert],
             list_sb.op_seen[OpEdit], list_sb.op_seen[OpDelete], list_sb.op_seen[OpGet]);
    $display("search %0d spare %0d, peak fill %0d; ok %0d empty %0d full %0d miss %0d",
             list_sb.op_seen[OpSearch], list_sb.op_seen[SpareOpA] + list_sb.op_seen[SpareOpB],
             list_sb.peak_fill, list_sb.status_seen[StatOk], list_sb.status_seen[StatEmpty],
             list_sb.status_seen[StatFull], list_sb.status_seen[StatMiss]);
    if (list_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d errors", list_sb.errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
